// File: src/assert_macros.svh
// Assertion macros shared by the checker's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define WFC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked on every rising edge, reset included.
`define WFC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);
`else
`define WFC_ASSERT(lbl, clk, rst_n, prop, msg)
`define WFC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// File: src/wfc_pkg.sv
package wfc_pkg;

    localparam int FIRST_BLOCK_DATA = 10;
    localparam int LATER_BLOCK_DATA = 16;
    localparam int BLOCK0_LEN       = FIRST_BLOCK_DATA + 2;
    localparam int POS_CRC_LOW      = LATER_BLOCK_DATA + 1;

    localparam logic [15:0] CRC_POLY      = 16'h3D65;
    localparam logic [7:0]  MAX_LEN_RESET = 8'd64;

    localparam int WFC_QUEUE_DEPTH = 4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_FRAME,
        PH_TOO_LONG,
        PH_CRC0_BAD
    } phase_t;

    typedef enum logic [2:0] {
        ST_GOOD,
        ST_TOO_SHORT,
        ST_CRC0_BAD,
        ST_TOO_LONG,
        ST_DATA_CRC_BAD
    } status_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] out_byte;
        status_t    status;
        logic [7:0] frame_len;
        logic       last;
    } result_t;

    // Up to two results per input byte: a payload byte and a verdict.
    typedef struct packed {
        logic    push0;
        logic    push1;
        result_t res0;
        result_t res1;
    } push_t;

    // One byte of the CRC-16 register update, most significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: src/wfc_ifs.sv
interface wfc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       frame_end;

    modport source (output valid, output rx_byte, output frame_start, output frame_end,
                    input ready);
    modport sink   (input valid, input rx_byte, input frame_start, input frame_end,
                    output ready);
endinterface

interface wfc_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [7:0] frame_len;
    logic       last;

    modport source (output valid, output kind, output out_byte, output status,
                    output frame_len, output last, input ready);
    modport sink   (input valid, input kind, input out_byte, input status,
                    input frame_len, input last, output ready);
endinterface

interface wfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: src/wfc_frame_core.sv
`include "assert_macros.svh"

module wfc_frame_core
    import wfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    wfc_in_if.sink     rx,
    input  logic [7:0] max_len,
    input  logic       space_ok,
    output push_t      push
);

    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_start_reg;
    logic        in_end_reg;
    logic        drain;

    logic [15:0] crc_reg,   crc_next;
    logic [7:0]  idx_reg,   idx_next;
    logic [7:0]  exp_reg,   exp_next;
    logic [4:0]  bpos_reg,  bpos_next;
    logic [7:0]  high_reg,  high_next;
    phase_t      phase_reg, phase_next;
    logic        derr_reg,  derr_next;

    logic [15:0] crc_eff;
    logic [7:0]  idx_eff;
    logic [4:0]  bpos_eff;
    logic [7:0]  high_eff;
    phase_t      phase_eff;
    logic        derr_eff;
    logic [7:0]  exp_eff;

    logic [9:0]  total;
    logic [9:0]  nblk;
    logic [7:0]  remaining;
    logic        crc_match;
    logic        pay;
    result_t     pay_res;
    result_t     ver_res;

    logic        verdict_push;
    logic        len_push;
    logic        good_push;

    // The input register is refilled when empty or when the result queue has room to drain it.
    assign drain    = in_vld_reg && space_ok;
    assign rx.ready = !in_vld_reg || drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (rx.ready)
            in_vld_reg <= rx.valid;
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg  <= rx.rx_byte;
            in_start_reg <= rx.frame_start;
            in_end_reg   <= rx.frame_end;
        end
    end

    always_comb
    begin
        crc_eff   = crc_reg;
        idx_eff   = idx_reg;
        bpos_eff  = bpos_reg;
        high_eff  = high_reg;
        phase_eff = phase_reg;
        derr_eff  = derr_reg;
        exp_eff   = exp_reg;
        if (in_start_reg)
        begin
            crc_eff   = '0;
            idx_eff   = '0;
            bpos_eff  = '0;
            high_eff  = '0;
            phase_eff = PH_FRAME;
            derr_eff  = 1'b0;
            exp_eff   = '0;
        end

        crc_next   = crc_eff;
        idx_next   = idx_eff;
        bpos_next  = bpos_eff;
        high_next  = high_eff;
        phase_next = phase_eff;
        derr_next  = derr_eff;
        exp_next   = exp_eff;
        pay        = 1'b0;

        // Total length from L, only meaningful for L of nine or more.
        nblk      = ({2'b00, in_byte_reg} + 10'd6) >> 4;
        total     = {2'b00, in_byte_reg} + 10'd3 + {nblk[8:0], 1'b0};
        remaining = exp_eff - idx_eff;
        crc_match = (crc_eff ^ 16'hFFFF) == {high_eff, in_byte_reg};

        if (phase_eff != PH_IDLE)
        begin
            if (idx_eff != 8'hFF)
                idx_next = idx_eff + 8'd1;

            if (idx_eff == 8'd0)
            begin
                if (in_byte_reg < 8'd9)
                    exp_next = in_byte_reg + 8'd3;
                else if (total > {2'b00, max_len})
                begin
                    phase_next = PH_TOO_LONG;
                    exp_next   = '0;
                end
                else
                    exp_next = total[7:0];
            end

            if (idx_eff < 8'(FIRST_BLOCK_DATA))
            begin
                crc_next = crc_byte(crc_eff, in_byte_reg);
                pay      = 1'b1;
            end
            else if (idx_eff == 8'(FIRST_BLOCK_DATA))
                high_next = in_byte_reg;
            else if (idx_eff == 8'(FIRST_BLOCK_DATA + 1))
            begin
                if (!crc_match)
                    phase_next = PH_CRC0_BAD;
                crc_next  = '0;
                bpos_next = '0;
            end
            else if (phase_eff == PH_FRAME && exp_eff >= 8'(BLOCK0_LEN) && idx_eff < exp_eff)
            begin
                if (bpos_eff == 5'(POS_CRC_LOW))
                begin
                    if (!crc_match)
                        derr_next = 1'b1;
                    crc_next  = '0;
                    bpos_next = '0;
                end
                else if (bpos_eff < 5'(LATER_BLOCK_DATA) && remaining > 8'd2)
                begin
                    crc_next  = crc_byte(crc_eff, in_byte_reg);
                    bpos_next = bpos_eff + 5'd1;
                    pay       = 1'b1;
                end
                else
                begin
                    high_next = in_byte_reg;
                    bpos_next = 5'(POS_CRC_LOW);
                end
            end
        end

        pay_res           = '0;
        pay_res.kind      = KIND_PAYLOAD;
        pay_res.out_byte  = in_byte_reg;
        pay_res.status    = ST_GOOD;

        ver_res           = '0;
        ver_res.kind      = KIND_VERDICT;
        ver_res.last      = 1'b1;
        if (idx_next < 8'(BLOCK0_LEN))
            ver_res.status = ST_TOO_SHORT;
        else if (phase_next == PH_CRC0_BAD)
            ver_res.status = ST_CRC0_BAD;
        else if (phase_next == PH_TOO_LONG)
            ver_res.status = ST_TOO_LONG;
        else if (exp_next < 8'(BLOCK0_LEN) || idx_next < exp_next)
            ver_res.status = ST_TOO_SHORT;
        else if (derr_next)
            ver_res.status = ST_DATA_CRC_BAD;
        else
        begin
            ver_res.status    = ST_GOOD;
            ver_res.frame_len = exp_next;
        end

        if (phase_eff != PH_IDLE && in_end_reg)
            phase_next = PH_IDLE;

        push.push0 = drain && phase_eff != PH_IDLE && (pay || in_end_reg);
        push.push1 = drain && phase_eff != PH_IDLE && pay && in_end_reg;
        push.res0  = pay ? pay_res : ver_res;
        push.res1  = ver_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= '0;
            idx_reg   <= '0;
            exp_reg   <= '0;
            bpos_reg  <= '0;
            high_reg  <= '0;
            phase_reg <= PH_IDLE;
            derr_reg  <= 1'b0;
        end
        else if (drain)
        begin
            crc_reg   <= crc_next;
            idx_reg   <= idx_next;
            exp_reg   <= exp_next;
            bpos_reg  <= bpos_next;
            high_reg  <= high_next;
            phase_reg <= phase_next;
            derr_reg  <= derr_next;
        end
    end

    assign verdict_push = push.push1 || (push.push0 && push.res0.kind == KIND_VERDICT);
    assign len_push     = push.push0 && push.res0.frame_len != 8'd0;
    assign good_push    = push.push0 && push.res0.kind == KIND_VERDICT
                          && push.res0.status == ST_GOOD;

    `WFC_ASSERT(a_verdict_closes, clk, rst_n, verdict_push |=> phase_reg == PH_IDLE, "frame left open")
    `WFC_ASSERT(a_len_only_good, clk, rst_n, len_push |-> good_push, "length on a bad verdict")
    `WFC_ASSERT(a_bpos_range, clk, rst_n, bpos_reg <= 5'(POS_CRC_LOW), "bad block position")

endmodule

// File: src/wfc_out_queue.sv
`include "assert_macros.svh"

module wfc_out_queue
    import wfc_pkg::*;
#(
    parameter int DEPTH = WFC_QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  push,
    output logic   space_ok,
    wfc_out_if.source result
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t       mem [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [PW-1:0] wptr1;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_dec;
    logic          pop;
    logic          pop_only;
    result_t       head;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    // Room for a whole input byte's results, whatever the sink does this cycle.
    assign space_ok = count_reg <= CW'(DEPTH - 2);
    assign wptr1    = ptr_inc(wptr_reg);
    assign pop      = result.valid && result.ready;
    assign pop_only = pop && !push.push0;
    assign count_dec = count_reg - CW'(1);
    assign head     = mem[rptr_reg];

    assign result.valid     = count_reg != '0;
    assign result.kind      = head.kind;
    assign result.out_byte  = head.out_byte;
    assign result.status    = head.status;
    assign result.frame_len = head.frame_len;
    assign result.last      = head.last;

    always_ff @(posedge clk)
    begin
        if (push.push0)
            mem[wptr_reg] <= push.res0;
        if (push.push1)
            mem[wptr1] <= push.res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push.push1)
                wptr_reg <= ptr_inc(wptr1);
            else if (push.push0)
                wptr_reg <= wptr1;
            if (pop)
                rptr_reg <= ptr_inc(rptr_reg);
            count_reg <= count_reg + CW'(push.push0) + CW'(push.push1) - CW'(pop);
        end
    end

    `WFC_ASSERT(a_count_bound, clk, rst_n, count_reg <= CW'(DEPTH), "result queue overflow")
    `WFC_ASSERT(a_push_room, clk, rst_n, push.push0 |-> space_ok, "push without room")
    `WFC_ASSERT(a_pop_count, clk, rst_n, pop_only |=> count_reg == $past(count_dec), "count lost a pop")

endmodule

// File: src/wmbus_frame_block_crc_checker.sv
// Path: a byte taken in is held in the input register, and its results are written into
// the result queue, from which they leave as result transfers.
// Throughput: one byte per cycle while the queue has room; a byte yielding a payload byte
// and a verdict at once needs two output transfers, absorbed by the result queue.
// Reset: asynchronous, active low; the frame tracker returns to idle, the queue empties
// and max_len_reg returns to 64.

module wmbus_frame_block_crc_checker
    import wfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = WFC_QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    wfc_in_if.sink    rx,
    wfc_out_if.source result,
    wfc_cfg_if.sink   cfg
);

    // The length limit register.  The user must write it only while no frame is being worked
    // on; the block itself does not enforce this, and cfg.ready is held high.
    logic [7:0] max_len_reg;
    push_t      push;
    logic       space_ok;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_len_reg <= MAX_LEN_RESET;
        else if (cfg.valid)
            max_len_reg <= cfg.data;
    end

    // The frame tracker holds one received byte in its input register and, in the same
    // cycle that it leaves, runs the CRC-16 update, the block position logic and the
    // verdict decision, writing up to two results into the queue.
    wfc_frame_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .max_len  (max_len_reg),
        .space_ok (space_ok),
        .push     (push)
    );

    // The result queue parts the two sides, so a stalled sink does not stall the
    // receiver until the queue has no room for another byte's results.
    wfc_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .space_ok (space_ok),
        .result   (result)
    );

endmodule
